// ===== sv/jlg_pkg.sv =====
// Shared types and constants for the Jacobi five-point Laplace grid solver.
// No dependencies; imported by every module of the block.
`default_nettype none

package jlg_pkg;

  // Default parameter values
  localparam int DEF_MAX_SIDE      = 128;
  localparam int DEF_VALUE_BITS    = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Boundary values in whole units: the low corner and the span along one edge
  localparam int BASE_LO   = 10;
  localparam int BASE_HI   = 20;
  localparam int EDGE_SPAN = BASE_HI - BASE_LO;

  // Configuration register reset values
  localparam logic [7:0]  GRID_SIDE_RST   = 8'd128;
  localparam logic [31:0] ERROR_LIMIT_RST = 32'd66;
  localparam logic [23:0] ITER_LIMIT_RST  = 24'd1000000;

  typedef enum logic [1:0] {
    REG_GRID_SIDE   = 2'd0,
    REG_ERROR_LIMIT = 2'd1,
    REG_ITER_LIMIT  = 2'd2
  } jlg_reg_e;

  localparam logic FUNC_SOLVE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Steps of one cell update: five reads of the source grid, then the write
  localparam logic [2:0] PH_NORTH  = 3'd0;
  localparam logic [2:0] PH_SOUTH  = 3'd1;
  localparam logic [2:0] PH_WEST   = 3'd2;
  localparam logic [2:0] PH_EAST   = 3'd3;
  localparam logic [2:0] PH_CENTER = 3'd4;
  localparam logic [2:0] PH_WRITE  = 3'd5;

  typedef struct packed {
    logic       solve_begin;
    logic       read_begin;
    logic       read_issue;
    logic       init_wr;
    logic       sweep_begin;
    logic       cell_op;
    logic [2:0] phase;
    logic       sweep_end;
    logic       finish_read;
    logic       finish_solve;
  } jlg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic init_last;
    logic cell_last;
    logic run_more;
  } jlg_sts_t;

endpackage

`default_nettype wire

// ===== sv/jlg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses jlg_pkg for the default of NW (DEF_FRACTION_BITS).
`default_nettype none

module jlg_div import jlg_pkg::*; #(
  parameter int NW = DEF_FRACTION_BITS + 4,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_d  = {quo_q[NW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== sv/jlg_datapath.sv =====
// Datapath: two grid buffers, edge interpolation, five-point average and
// change tracking. Depends on jlg_pkg and jlg_div.
`default_nettype none

module jlg_datapath import jlg_pkg::*; #(
  parameter int MAX_SIDE      = DEF_MAX_SIDE,
  parameter int VALUE_BITS    = DEF_VALUE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  jlg_cmd_t    cmd_i,
  output jlg_sts_t    sts_o,
  input  logic [7:0]  grid_side_i,
  input  logic [31:0] error_limit_i,
  input  logic [23:0] iteration_limit_i,
  input  logic [6:0]  row_i,
  input  logic [6:0]  col_i,
  output logic        is_read_o,
  output logic [23:0] iterations_done_o,
  output logic [31:0] final_error_o,
  output logic [31:0] cell_value_o
);

  localparam int RW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = FRACTION_BITS + 4;
  localparam int EW    = FRACTION_BITS + 6;
  localparam int V     = VALUE_BITS;
  localparam logic [NW-1:0] SPAN   = NW'(64'(EDGE_SPAN) << FRACTION_BITS);
  localparam logic [63:0]   VMASK  = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [AW-1:0] STEP_M = AW'(MAX_SIDE);

  function automatic logic [V-1:0] sat_ev(input logic [EW-1:0] e);
    logic [63:0] w;
    w = 64'(e);
    if (w > VMASK) w = VMASK;
    return w[V-1:0];
  endfunction

  // side as used now, saturated into 3..MAX_SIDE
  logic [SW-1:0] side_c;
  always_comb begin
    if (grid_side_i < 8'd3) side_c = SW'(3);
    else if (32'(grid_side_i) > MAX_SIDE) side_c = SW'(MAX_SIDE);
    else side_c = SW'(grid_side_i);
  end

  logic [SW-1:0] side_q, d_w, period;
  logic [RW-1:0] d_r, dm1_r;
  logic [RW-1:0] r_q, c_q;
  logic [AW-1:0] k, ra, rd_addr_q;
  logic          inrange_q;

  assign d_w    = side_q - SW'(1);
  assign d_r    = d_w[RW-1:0];
  assign dm1_r  = d_r - RW'(1);
  assign period = side_q >> 1;
  assign k      = AW'(32'(r_q) * MAX_SIDE + 32'(c_q));

  // Edge increment per step: 10.0 / d as quotient and remainder
  logic          div_done;
  logic [NW-1:0] addq;
  logic [SW-1:0] addr_rem;

  jlg_div #(.NW(NW), .DW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.solve_begin),
    .num_i   (SPAN),
    .den_i   (side_c - SW'(1)),
    .done_o  (div_done),
    .quo_o   (addq),
    .rem_o   (addr_rem)
  );

  // Incremental interpolation along columns (qc) and rows (qr)
  logic [NW-1:0] qc_q, qr_q, qc_sum, qr_sum, qc_nx, qr_nx;
  logic [SW-1:0] remc_q, remr_q, remc_nx, remr_nx;
  logic [SW:0]   rc_sum, rr_sum, rc_sub, rr_sub, d_x;

  assign d_x    = {1'b0, d_w};
  assign qc_sum = qc_q + addq;
  assign qr_sum = qr_q + addq;
  assign rc_sum = {1'b0, remc_q} + {1'b0, addr_rem};
  assign rr_sum = {1'b0, remr_q} + {1'b0, addr_rem};
  assign rc_sub = rc_sum - d_x;
  assign rr_sub = rr_sum - d_x;
  assign qc_nx  = (rc_sum >= d_x) ? qc_sum + NW'(1) : qc_sum;
  assign qr_nx  = (rr_sum >= d_x) ? qr_sum + NW'(1) : qr_sum;
  assign remc_nx = (rc_sum >= d_x) ? rc_sub[SW-1:0] : rc_sum[SW-1:0];
  assign remr_nx = (rr_sum >= d_x) ? rr_sub[SW-1:0] : rr_sum[SW-1:0];

  logic [EW-1:0] e_lo_c, e_hi_c, e_lo_r, e_hi_r;
  assign e_lo_c = (EW'(BASE_LO) << FRACTION_BITS) + EW'(qc_q);
  assign e_hi_c = (EW'(BASE_HI) << FRACTION_BITS) + EW'(qc_q);
  assign e_lo_r = (EW'(BASE_LO) << FRACTION_BITS) + EW'(qr_q);
  assign e_hi_r = (EW'(BASE_HI) << FRACTION_BITS) + EW'(qr_q);

  logic [V-1:0] init_val;
  always_comb begin
    if (r_q == '0)        init_val = sat_ev(e_lo_c);
    else if (r_q == d_r)  init_val = sat_ev(e_hi_c);
    else if (c_q == '0)   init_val = sat_ev(e_lo_r);
    else if (c_q == d_r)  init_val = sat_ev(e_hi_r);
    else                  init_val = '0;
  end

  // Grid buffers
  logic [V-1:0] mem_a [DEPTH];
  logic [V-1:0] mem_b [DEPTH];
  logic [V-1:0] rd_a_q, rd_b_q, rd_sel, wd;
  logic         we_a, we_b, cur_b_q, wr_step;

  assign wr_step = cmd_i.cell_op && (cmd_i.phase == PH_WRITE);
  assign we_a    = cmd_i.init_wr || (wr_step && cur_b_q);
  assign we_b    = cmd_i.init_wr || (wr_step && !cur_b_q);
  assign rd_sel  = cur_b_q ? rd_b_q : rd_a_q;

  always_comb begin
    ra = k;
    if (cmd_i.read_issue) begin
      ra = rd_addr_q;
    end else if (cmd_i.cell_op) begin
      case (cmd_i.phase)
        PH_NORTH: ra = k - STEP_M;
        PH_SOUTH: ra = k + STEP_M;
        PH_WEST:  ra = k - AW'(1);
        PH_EAST:  ra = k + AW'(1);
        default:  ra = k;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[k] <= wd;
    rd_a_q <= mem_a[ra];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[k] <= wd;
    rd_b_q <= mem_b[ra];
  end

  // Five-point update: average of the four neighbours and change from the centre
  logic [V+1:0] sum_q;
  logic [V-1:0] newv, delta, max_q;
  assign newv  = sum_q[V+1:2];
  assign delta = (newv > rd_sel) ? newv - rd_sel : rd_sel - newv;
  assign wd    = cmd_i.init_wr ? init_val : newv;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_op) begin
      case (cmd_i.phase)
        PH_SOUTH:                   sum_q <= (V+2)'(rd_sel);
        PH_WEST, PH_EAST, PH_CENTER: sum_q <= sum_q + (V+2)'(rd_sel);
        default:                    sum_q <= sum_q;
      endcase
    end
  end

  // Sweep bookkeeping
  logic [23:0]   cnt_q, cnt_n;
  logic [SW-1:0] pc_q, pc_n;
  logic          measured_q, worst_hi_q, meas;
  logic [31:0]   worst_q, worst_init;
  logic [63:0]   mx64, wi64, rd64;
  logic          is_read_q;
  logic [31:0]   cell_q;

  assign cnt_n = cnt_q + 24'd1;
  assign pc_n  = pc_q + SW'(1);
  assign meas  = (pc_n == period) || (cnt_n == iteration_limit_i);
  assign mx64  = 64'(max_q);
  assign rd64  = 64'(rd_sel);

  always_comb begin
    wi64 = (error_limit_i == 32'hFFFF_FFFF) ? 64'h0000_0000_FFFF_FFFF
                                            : 64'(error_limit_i) + 64'd1;
    if (wi64 > VMASK) wi64 = VMASK;
    worst_init = wi64[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= SW'(3);
      r_q        <= '0;
      c_q        <= '0;
      qc_q       <= '0;
      qr_q       <= '0;
      remc_q     <= '0;
      remr_q     <= '0;
      rd_addr_q  <= '0;
      inrange_q  <= 1'b0;
      cur_b_q    <= 1'b0;
      cnt_q      <= '0;
      pc_q       <= '0;
      measured_q <= 1'b0;
      worst_q    <= 32'hFFFF_FFFF;
      worst_hi_q <= 1'b0;
      max_q      <= '0;
      is_read_q  <= 1'b0;
      cell_q     <= '0;
    end else begin
      if (cmd_i.solve_begin) begin
        side_q     <= side_c;
        r_q        <= '0;
        c_q        <= '0;
        qc_q       <= '0;
        qr_q       <= '0;
        remc_q     <= (side_c - SW'(1)) >> 1;
        remr_q     <= (side_c - SW'(1)) >> 1;
        cur_b_q    <= 1'b0;
        cnt_q      <= '0;
        pc_q       <= '0;
        measured_q <= 1'b0;
        worst_q    <= worst_init;
        worst_hi_q <= 1'b0;
      end
      if (cmd_i.read_begin) begin
        rd_addr_q <= AW'(32'(row_i) * MAX_SIDE + 32'(col_i));
        inrange_q <= (32'(row_i) < 32'(side_c)) && (32'(col_i) < 32'(side_c));
      end
      if (cmd_i.init_wr) begin
        if (c_q == d_r) begin
          c_q    <= '0;
          r_q    <= r_q + RW'(1);
          qc_q   <= '0;
          remc_q <= d_w >> 1;
          qr_q   <= qr_nx;
          remr_q <= remr_nx;
        end else begin
          c_q    <= c_q + RW'(1);
          qc_q   <= qc_nx;
          remc_q <= remc_nx;
        end
      end
      if (cmd_i.sweep_begin) begin
        r_q   <= RW'(1);
        c_q   <= RW'(1);
        max_q <= '0;
      end
      if (wr_step) begin
        if (delta > max_q) max_q <= delta;
        if (c_q == dm1_r) begin
          c_q <= RW'(1);
          r_q <= r_q + RW'(1);
        end else begin
          c_q <= c_q + RW'(1);
        end
      end
      if (cmd_i.sweep_end) begin
        cnt_q   <= cnt_n;
        cur_b_q <= !cur_b_q;
        pc_q    <= (pc_n == period) ? '0 : pc_n;
        if (meas) begin
          measured_q <= 1'b1;
          worst_q    <= mx64[31:0];
          worst_hi_q <= |mx64[63:32];
        end
      end
      if (cmd_i.finish_read) begin
        is_read_q <= 1'b1;
        cell_q    <= inrange_q ? rd64[31:0] : 32'd0;
      end
      if (cmd_i.finish_solve) begin
        is_read_q <= 1'b0;
        cell_q    <= '0;
      end
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.init_last = (r_q == d_r) && (c_q == d_r);
  assign sts_o.cell_last = (r_q == dm1_r) && (c_q == dm1_r);
  assign sts_o.run_more  = (!measured_q || worst_hi_q || (worst_q > error_limit_i))
                           && (cnt_q < iteration_limit_i);

  assign is_read_o         = is_read_q;
  assign iterations_done_o = cnt_q;
  assign final_error_o     = worst_hi_q ? 32'hFFFF_FFFF : worst_q;
  assign cell_value_o      = cell_q;

endmodule

`default_nettype wire

// ===== sv/jlg_ctrl.sv =====
// Controller: sequences grid setup, sweeps, convergence checks and reads.
// Depends on jlg_pkg for the command and status structs.
`default_nettype none

module jlg_ctrl import jlg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     func_i,
  input  jlg_sts_t sts_i,
  output jlg_cmd_t cmd_o,
  output logic     busy,
  output logic     done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_DATA,
    ST_DIV,
    ST_INIT,
    ST_CHECK,
    ST_CELL,
    ST_END
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (func_i == FUNC_READ) begin
            cmd_o.read_begin = 1'b1;
            state_d = ST_READ;
          end else begin
            cmd_o.solve_begin = 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_READ: begin
        cmd_o.read_issue = 1'b1;
        state_d = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        cmd_o.finish_read = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.run_more) begin
          cmd_o.sweep_begin = 1'b1;
          phase_d = PH_NORTH;
          state_d = ST_CELL;
        end else begin
          cmd_o.finish_solve = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CELL: begin
        cmd_o.cell_op = 1'b1;
        cmd_o.phase   = phase_q;
        if (phase_q == PH_WRITE) begin
          phase_d = PH_NORTH;
          if (sts_i.cell_last) state_d = ST_END;
        end else begin
          phase_d = phase_q + 3'd1;
        end
      end
      ST_END: begin
        cmd_o.sweep_end = 1'b1;
        state_d = ST_CHECK;
      end
      default: state_d = ST_IDLE;
    endcase
    done_d = cmd_o.finish_read || cmd_o.finish_solve;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_NORTH;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== sv/jacobi_laplace_grid_solver_top.sv =====
// Top level of the Jacobi five-point Laplace grid solver: configuration
// registers, controller and datapath. Depends on jlg_pkg, jlg_ctrl, jlg_datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  command  | start, busy        | func_i, row_i, col_i
//  result   | done_o (1 cycle)   | is_read_o, iterations_done_o,
//           |                    | final_error_o, cell_value_o
//  config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A read passes through ST_READ, which issues the one buffer read, and
// ST_READ_DATA; done_o is registered from ST_READ_DATA. A solve on side S first
// waits for the edge step divider, then writes S*S cells, one per cycle, into both
// buffers, then runs sweeps (the single buffer read port is used five times per
// interior cell, then the cell is written) with a check before each sweep, and one
// last check; done_o rises on the edge that ends that check.
// Reset clears control state and sets the configuration registers to their
// defaults; grid buffers are not cleared. The result receiver cannot stall.
`default_nettype none

module jacobi_laplace_grid_solver_top import jlg_pkg::*; #(
  parameter int MAX_SIDE      = DEF_MAX_SIDE,
  parameter int VALUE_BITS    = DEF_VALUE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [6:0]  row_i,
  input  logic [6:0]  col_i,
  output logic        done_o,
  output logic        is_read_o,
  output logic [23:0] iterations_done_o,
  output logic [31:0] final_error_o,
  output logic [31:0] cell_value_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [7:0]  grid_side_q;
  logic [31:0] error_limit_q;
  logic [23:0] iter_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q   <= GRID_SIDE_RST;
      error_limit_q <= ERROR_LIMIT_RST;
      iter_limit_q  <= ITER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_SIDE:   grid_side_q   <= cfg_data_i[7:0];
        REG_ERROR_LIMIT: error_limit_q <= cfg_data_i;
        REG_ITER_LIMIT:  iter_limit_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  jlg_cmd_t cmd;
  jlg_sts_t sts;

  jlg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  jlg_datapath #(
    .MAX_SIDE      (MAX_SIDE),
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .grid_side_i       (grid_side_q),
    .error_limit_i     (error_limit_q),
    .iteration_limit_i (iter_limit_q),
    .row_i             (row_i),
    .col_i             (col_i),
    .is_read_o         (is_read_o),
    .iterations_done_o (iterations_done_o),
    .final_error_o     (final_error_o),
    .cell_value_o      (cell_value_o)
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted transaction did not start");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !is_read_o |-> iterations_done_o <= iter_limit_q)
    else $error("sweep count above limit");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_jacobi_laplace_grid_solver_top.sv =====
// Self-checking testbench for jacobi_laplace_grid_solver_top: a directed table and then
// random solve/read phases, all checked against a behavioral grid solver kept here
// or against fixed results in the table. Depends on jlg_pkg and the solver RTL.
`timescale 1ns / 1ps

module tb_jacobi_laplace_grid_solver_top;
  import jlg_pkg::*;

  localparam int SIDE_MAX = 128;
  localparam int CELLS    = SIDE_MAX * SIDE_MAX;
  localparam longint unsigned VMAX = 64'hFFFF_FFFF;

  typedef struct {
    logic        is_read;
    logic [23:0] iters;
    logic [31:0] err;
    logic [31:0] cell_val;
  } grid_result_t;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;

  typedef struct {
    row_kind_e    kind;
    jlg_reg_e     idx;
    logic [31:0]  data;
    logic         func;
    logic [6:0]   row;
    logic [6:0]   col;
    logic         fixed;
    grid_result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = FUNC_SOLVE;
  logic [6:0]  row_i = '0;
  logic [6:0]  col_i = '0;
  logic        done_o;
  logic        is_read_o;
  logic [23:0] iterations_done_o;
  logic [31:0] final_error_o;
  logic [31:0] cell_value_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_GRID_SIDE;
  logic [31:0] cfg_data_i = '0;

  jacobi_laplace_grid_solver_top u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .row_i, .col_i,
    .done_o, .is_read_o, .iterations_done_o, .final_error_o, .cell_value_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral copy of the solver state
  longint unsigned grid_a[CELLS];
  longint unsigned grid_b[CELLS];
  bit              on_b;
  longint unsigned last_sweeps;
  longint unsigned last_worst;
  longint unsigned side_reg, err_lim_reg, iter_lim_reg;

  grid_result_t result_q[$];
  int mismatches = 0;
  int n_solves = 0, n_reads = 0, n_items = 0;
  bit quiet = 1'b0;

  function automatic longint unsigned clip(longint unsigned x);
    return (x > VMAX) ? VMAX : x;
  endfunction

  function automatic longint unsigned eff_side();
    if (side_reg < 3) return 3;
    if (side_reg > SIDE_MAX) return SIDE_MAX;
    return side_reg;
  endfunction

  function automatic longint unsigned edge_cell(longint unsigned base, longint unsigned i,
                                                longint unsigned d);
    longint unsigned num;
    num = (longint'(EDGE_SPAN) << 16) * i + d / 2;
    return clip((base << 16) + num / d);
  endfunction

  function automatic void build_grid(bit to_b, longint unsigned s);
    longint unsigned d, g[CELLS];
    d = s - 1;
    foreach (g[k]) g[k] = 0;
    g[0] = clip(longint'(BASE_LO) << 16);
    g[d] = clip(longint'(BASE_HI) << 16);
    g[d * SIDE_MAX] = clip(longint'(BASE_HI) << 16);
    g[d * SIDE_MAX + d] = clip(longint'(BASE_HI + EDGE_SPAN) << 16);
    for (longint unsigned i = 1; i < d; i++) begin
      g[i] = edge_cell(BASE_LO, i, d);
      g[i * SIDE_MAX + d] = edge_cell(BASE_HI, i, d);
      g[d * SIDE_MAX + i] = edge_cell(BASE_HI, i, d);
      g[i * SIDE_MAX] = edge_cell(BASE_LO, i, d);
    end
    if (to_b) grid_b = g;
    else grid_a = g;
  endfunction

  function automatic void run_solve();
    longint unsigned s, period, lim, ilim, worst, count, m, dlt, k, nv;
    bit measured;
    s = eff_side();
    period = s / 2;
    lim = err_lim_reg;
    ilim = iter_lim_reg;
    worst = clip(lim + 1);
    count = 0;
    measured = 0;
    build_grid(0, s);
    build_grid(1, s);
    on_b = 0;
    while ((!measured || worst > lim) && count < ilim) begin
      count++;
      m = 0;
      for (longint unsigned r = 1; r + 1 < s; r++)
        for (longint unsigned c = 1; c + 1 < s; c++) begin
          k = r * SIDE_MAX + c;
          if (on_b) begin
            nv = (grid_b[k - SIDE_MAX] + grid_b[k + SIDE_MAX] + grid_b[k - 1]
                  + grid_b[k + 1]) >> 2;
            dlt = (nv > grid_b[k]) ? nv - grid_b[k] : grid_b[k] - nv;
            grid_a[k] = nv;
          end else begin
            nv = (grid_a[k - SIDE_MAX] + grid_a[k + SIDE_MAX] + grid_a[k - 1]
                  + grid_a[k + 1]) >> 2;
            dlt = (nv > grid_a[k]) ? nv - grid_a[k] : grid_a[k] - nv;
            grid_b[k] = nv;
          end
          if (dlt > m) m = dlt;
        end
      on_b = !on_b;
      if (count % period == 0 || count == ilim) begin
        worst = m;
        measured = 1;
      end
    end
    last_sweeps = count & 64'hFF_FFFF;
    last_worst = (worst > VMAX) ? VMAX : worst;
  endfunction

  function automatic grid_result_t predict_item(logic func, logic [6:0] row, logic [6:0] col);
    grid_result_t res;
    longint unsigned s;
    res.cell_val = '0;
    if (func == FUNC_SOLVE) begin
      run_solve();
    end else begin
      s = eff_side();
      if (row < s && col < s)
        res.cell_val = on_b ? 32'(grid_b[row * SIDE_MAX + col])
                            : 32'(grid_a[row * SIDE_MAX + col]);
    end
    res.is_read = func;
    res.iters = last_sweeps[23:0];
    res.err = last_worst[31:0];
    return res;
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 14)) @(negedge clk_i);
  endtask

  task automatic write_reg(jlg_reg_e idx, logic [31:0] data);
    // registers only change with the solver idle
    wait (result_q.size() == 0);
    repeat (3) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      REG_GRID_SIDE:   side_reg = data[7:0];
      REG_ERROR_LIMIT: err_lim_reg = data;
      REG_ITER_LIMIT:  iter_lim_reg = data[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_item(logic func, logic [6:0] row, logic [6:0] col,
                           logic fixed, grid_result_t fixed_res);
    grid_result_t res;
    idle_gap();
    @(negedge clk_i);
    start = 1'b1;
    func_i = func;
    row_i = row;
    col_i = col;
    do @(posedge clk_i); while (busy);
    res = predict_item(func, row, col);
    result_q.push_back(fixed ? fixed_res : res);
    if (func == FUNC_SOLVE) n_solves++;
    else n_reads++;
    n_items++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Result checker: one transaction per done_o pulse
  always @(posedge clk_i) begin
    grid_result_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result transaction with none pending");
      end else begin
        want = result_q.pop_front();
        if (is_read_o !== want.is_read || iterations_done_o !== want.iters
            || final_error_o !== want.err || cell_value_o !== want.cell_val) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp rd=%0d it=%0d err=%h cell=%h, got rd=%0d it=%0d err=%h cell=%h",
                     want.is_read, want.iters, want.err, want.cell_val, is_read_o,
                     iterations_done_o, final_error_o, cell_value_o);
        end
      end
    end
  end

  function automatic stim_row_t cfg_row(jlg_reg_e idx, logic [31:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, func: FUNC_SOLVE, row: '0, col: '0,
          fixed: 1'b0, res: '{1'b0, '0, '0, '0}};
    return r;
  endfunction

  function automatic stim_row_t item_row(logic func, logic [6:0] row, logic [6:0] col);
    stim_row_t r;
    r = cfg_row(REG_GRID_SIDE, '0);
    r.kind = ROW_ITEM;
    r.func = func;
    r.row = row;
    r.col = col;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic func, logic [6:0] row, logic [6:0] col,
                                         logic [31:0] err, logic [31:0] cell_val);
    stim_row_t r;
    r = item_row(func, row, col);
    r.fixed = 1'b1;
    r.res = '{func, 24'd0, err, cell_val};
    return r;
  endfunction

  initial begin
    stim_row_t tbl[$];
    logic [7:0] side;
    side_reg = GRID_SIDE_RST;
    err_lim_reg = ERROR_LIMIT_RST;
    iter_lim_reg = ITER_LIMIT_RST;
    on_b = 0;
    last_sweeps = 0;
    last_worst = VMAX;
    foreach (grid_a[k]) begin
      grid_a[k] = 0;
      grid_b[k] = 0;
    end

    // side above range saturates, no sweep allowed: error reports limit+1 clipped
    tbl.push_back(cfg_row(REG_GRID_SIDE, 32'd255));
    tbl.push_back(cfg_row(REG_ERROR_LIMIT, 32'hFFFF_FFFF));
    tbl.push_back(cfg_row(REG_ITER_LIMIT, 32'd0));
    tbl.push_back(known_row(FUNC_SOLVE, 7'd0, 7'd0, 32'hFFFF_FFFF, 32'd0));
    tbl.push_back(known_row(FUNC_READ, 7'd0, 7'd0, 32'hFFFF_FFFF, 32'h000A_0000));
    tbl.push_back(known_row(FUNC_READ, 7'd127, 7'd127, 32'hFFFF_FFFF, 32'h001E_0000));
    tbl.push_back(known_row(FUNC_READ, 7'd127, 7'd0, 32'hFFFF_FFFF, 32'h0014_0000));
    tbl.push_back(item_row(FUNC_READ, 7'd0, 7'd64));
    // side below range becomes 3
    tbl.push_back(cfg_row(REG_GRID_SIDE, 32'd0));
    tbl.push_back(cfg_row(REG_ERROR_LIMIT, 32'd5));
    tbl.push_back(known_row(FUNC_SOLVE, 7'd5, 7'd9, 32'd6, 32'd0));
    tbl.push_back(known_row(FUNC_READ, 7'd1, 7'd1, 32'd6, 32'd0));
    tbl.push_back(known_row(FUNC_READ, 7'd3, 7'd1, 32'd6, 32'd0));
    tbl.push_back(known_row(FUNC_READ, 7'd127, 7'd127, 32'd6, 32'd0));
    // deepest iteration limit, converges after the first sweep
    tbl.push_back(cfg_row(REG_ITER_LIMIT, 32'hFF_FFFF));
    tbl.push_back(cfg_row(REG_ERROR_LIMIT, 32'hFFFF_FFFF));
    tbl.push_back(item_row(FUNC_SOLVE, 7'd0, 7'd0));
    tbl.push_back(item_row(FUNC_READ, 7'd1, 7'd1));
    // full-size grid, one sweep, last sweep is measured
    tbl.push_back(cfg_row(REG_GRID_SIDE, 32'd128));
    tbl.push_back(cfg_row(REG_ERROR_LIMIT, 32'd0));
    tbl.push_back(cfg_row(REG_ITER_LIMIT, 32'd1));
    tbl.push_back(item_row(FUNC_SOLVE, 7'd0, 7'd0));
    tbl.push_back(item_row(FUNC_READ, 7'd1, 7'd1));
    tbl.push_back(item_row(FUNC_READ, 7'd126, 7'd126));
    tbl.push_back(item_row(FUNC_READ, 7'd64, 7'd127));
    // exact convergence to zero change
    tbl.push_back(cfg_row(REG_GRID_SIDE, 32'd2));
    tbl.push_back(cfg_row(REG_ITER_LIMIT, 32'd300));
    tbl.push_back(item_row(FUNC_SOLVE, 7'd0, 7'd0));
    tbl.push_back(item_row(FUNC_READ, 7'd1, 7'd1));
    tbl.push_back(cfg_row(REG_GRID_SIDE, 32'd7));
    tbl.push_back(cfg_row(REG_ERROR_LIMIT, 32'd66));
    tbl.push_back(cfg_row(REG_ITER_LIMIT, 32'd200));
    tbl.push_back(item_row(FUNC_SOLVE, 7'd0, 7'd0));
    tbl.push_back(item_row(FUNC_READ, 7'd3, 7'd3));
    tbl.push_back(item_row(FUNC_READ, 7'd2, 7'd5));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    foreach (tbl[i]) begin
      if (tbl[i].kind == ROW_CFG) write_reg(tbl[i].idx, tbl[i].data);
      else send_item(tbl[i].func, tbl[i].row, tbl[i].col, tbl[i].fixed, tbl[i].res);
    end

    // random phases: new settings, one solve, then reads of the fresh grid
    while (n_items < 100) begin
      quiet = (n_items > 88);
      side = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(3, 10));
      write_reg(REG_GRID_SIDE, {24'd0, side});
      case ($urandom_range(0, 2))
        0: write_reg(REG_ERROR_LIMIT, $urandom());
        1: write_reg(REG_ERROR_LIMIT, $urandom_range(0, 4096));
        default: write_reg(REG_ERROR_LIMIT, $urandom_range(0, 400000));
      endcase
      write_reg(REG_ITER_LIMIT, $urandom_range(0, 40));
      send_item(FUNC_SOLVE, 7'($urandom()), 7'($urandom()), 1'b0, '{1'b0, '0, '0, '0});
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 3) == 0)
          send_item(FUNC_READ, 7'($urandom()), 7'($urandom()), 1'b0, '{1'b0, '0, '0, '0});
        else
          send_item(FUNC_READ, 7'($urandom_range(0, 32'(eff_side() - 1))),
                    7'($urandom_range(0, 32'(eff_side() - 1))), 1'b0, '{1'b0, '0, '0, '0});
      end
    end

    wait (result_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d solves and %0d cell reads over side, threshold and sweep limits",
             n_solves, n_reads);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
